[rtl/cabac_pkg.sv]
// ----------------------------------------------------------------------------
// CABAC decoder package
// Shared types, constants and tables of the CABAC arithmetic decoding engine.
// ----------------------------------------------------------------------------
package cabac_pkg;

   localparam int CONTEXTS    = 1024;
   localparam int CTX_AW      = $clog2(CONTEXTS);
   localparam int BUFFER_BITS = 32;
   localparam int CNT_W       = $clog2(BUFFER_BITS + 1);

   typedef enum logic [2:0] {
      ACT_FEED      = 3'd0,
      ACT_CTX_WRITE = 3'd1,
      ACT_START     = 3'd2,
      ACT_DECISION  = 3'd3,
      ACT_BYPASS    = 3'd4,
      ACT_TERMINATE = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_STARVED = 2'd1,
      ST_FULL    = 2'd2,
      ST_ALIGN   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [9:0] ctx_index;
      logic [2:0] action;
   } req_type;

   typedef struct packed {
      logic       end_seen;
      status_type status;
      logic       bin_value;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [CTX_AW-1:0] addr;
      logic [6:0]        data;
   } ctx_wr_type;

   localparam logic [7:0] LPS_TABLE [64][4] = '{
      '{128,176,208,240},'{128,167,197,227},'{128,158,187,216},'{123,150,178,205},
      '{116,142,169,195},'{111,135,160,185},'{105,128,152,175},'{100,122,144,166},
      '{95,116,137,158},'{90,110,130,150},'{85,104,123,142},'{81,99,117,135},
      '{77,94,111,128},'{73,89,105,122},'{69,85,100,116},'{66,80,95,110},
      '{62,76,90,104},'{59,72,86,99},'{56,69,81,94},'{53,65,77,89},
      '{51,62,73,85},'{48,59,69,80},'{46,56,66,76},'{43,53,63,72},
      '{41,50,59,69},'{39,48,56,65},'{37,45,54,62},'{35,43,51,59},
      '{33,41,48,56},'{32,39,46,53},'{30,37,43,50},'{29,35,41,48},
      '{27,33,39,45},'{26,31,37,43},'{24,30,35,41},'{23,28,33,39},
      '{22,27,32,37},'{21,26,30,35},'{20,24,29,33},'{19,23,27,31},
      '{18,22,26,30},'{17,21,25,28},'{16,20,23,27},'{15,19,22,25},
      '{14,18,21,24},'{14,17,20,23},'{13,16,19,22},'{12,15,18,21},
      '{12,14,17,20},'{11,14,16,19},'{11,13,15,18},'{10,12,15,17},
      '{10,12,14,16},'{9,11,13,15},'{9,11,12,14},'{8,10,12,14},
      '{8,9,11,13},'{7,9,11,12},'{7,9,10,12},'{7,8,10,11},
      '{6,8,9,11},'{6,7,9,10},'{6,7,8,9},'{2,2,2,2}
   };

   localparam logic [5:0] NEXT_ON_LPS [64] = '{
      0,0,1,2,2,4,4,5,6,7,8,9,9,11,11,12,
      13,13,15,15,16,16,18,18,19,19,21,21,22,22,23,24,
      24,25,26,26,27,27,28,29,29,30,30,30,31,32,32,33,
      33,33,34,34,35,35,35,36,36,36,37,37,37,38,38,63
   };

   // Leading-zero count of a 9-bit range; zero gives 9.
   function automatic logic [3:0] renorm_shift(input logic [8:0] r);
      logic [3:0] s;
      s = 4'd9;
      for (int i = 0; i < 9; i++) begin
         if (r[i]) begin
            s = 4'(8 - i);
         end
      end
      return s;
   endfunction

endpackage

[rtl/cabac_ctx_mem.sv]
// ----------------------------------------------------------------------------
// CABAC context memory
// Synchronous context store with registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
module cabac_ctx_mem
   import cabac_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [CTX_AW-1:0] rd_addr,
   input  ctx_wr_type        wr,
   output logic [6:0]        rd_data
);

   logic [6:0] mem [CONTEXTS];
   logic [6:0] q_ff;
   logic [6:0] fwd_ff;
   logic       fwd_sel_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         q_ff   <= mem[rd_addr];
         fwd_ff <= wr.data;
      end
   end

   // A write in the same cycle as the read to the same entry wins.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_sel_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_sel_ff <= wr.we && (wr.addr == rd_addr);
      end
   end

   assign rd_data = fwd_sel_ff ? fwd_ff : q_ff;

endmodule

[rtl/cabac_engine.sv]
// ----------------------------------------------------------------------------
// CABAC engine
// Range, offset and bit-buffer state and the per-item arithmetic decode step.
// ----------------------------------------------------------------------------
module cabac_engine
   import cabac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       exec,
   input  req_type    req,
   input  logic [6:0] ctx_val,
   output rsp_type    rsp,
   output ctx_wr_type ctx_wr
);

   logic [8:0]             range_ff, range_in;
   logic [8:0]             offset_ff, offset_in;
   logic [BUFFER_BITS-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]             zrun_ff, zrun_in;
   logic                   ended_ff, ended_in;

   logic                   in_range;
   logic [5:0]             st;
   logic                   mps;
   logic [7:0]             lps;
   logic [8:0]             rd;
   logic                   lps_path;
   logic [8:0]             dec_r;
   logic [8:0]             dec_o;
   logic [3:0]             dec_s;
   logic [8:0]             term_r;
   logic [3:0]             term_s;
   logic                   term_hit;
   logic [2:0]             align;
   logic [CNT_W-1:0]       need;
   logic                   ready;
   logic [BUFFER_BITS-1:0] mask_n;
   logic [BUFFER_BITS-1:0] tv_full;
   logic [15:0]            tv;
   logic [CNT_W-1:0]       cnt_taken;
   logic [17:0]            shifted;
   logic [9:0]             byp_o;
   logic [5:0]             nst;
   logic                   nmps;

   assign in_range = {1'b0, req.ctx_index} < 11'(CONTEXTS);
   assign st       = in_range ? ctx_val[6:1] : 6'd0;
   assign mps      = in_range ? ctx_val[0] : 1'b0;
   assign lps      = LPS_TABLE[st][range_ff[7:6]];
   assign rd       = range_ff - {1'b0, lps};
   assign lps_path = offset_ff >= rd;
   assign dec_r    = lps_path ? {1'b0, lps} : rd;
   assign dec_o    = lps_path ? (offset_ff - rd) : offset_ff;
   assign dec_s    = renorm_shift(dec_r);
   assign term_r   = range_ff - 9'd2;
   assign term_s   = renorm_shift(term_r);
   assign term_hit = offset_ff >= term_r;
   assign align    = cnt_ff[2:0];

   always_comb begin
      case (req.action)
         ACT_START:     need = CNT_W'(align) + CNT_W'(9);
         ACT_DECISION:  need = CNT_W'(dec_s);
         ACT_BYPASS:    need = CNT_W'(1);
         ACT_TERMINATE: need = term_hit ? '0 : CNT_W'(term_s);
         default:       need = '0;
      endcase
   end

   assign ready = ended_ff || (cnt_ff >= need);

   // Oldest bits first; bits missing after the end of the stream read as zero.
   always_comb begin
      mask_n = (BUFFER_BITS'(1) << need) - BUFFER_BITS'(1);
      if (cnt_ff >= need) begin
         tv_full   = (buf_ff >> (cnt_ff - need)) & mask_n;
         cnt_taken = cnt_ff - need;
      end else begin
         tv_full   = (buf_ff & ((BUFFER_BITS'(1) << cnt_ff) - BUFFER_BITS'(1)))
                     << (need - cnt_ff);
         cnt_taken = '0;
      end
      tv = tv_full[15:0];
   end

   always_comb begin
      range_in  = range_ff;
      offset_in = offset_ff;
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      zrun_in   = zrun_ff;
      ended_in  = ended_ff;
      rsp.bin_value = 1'b0;
      rsp.status    = ST_OK;
      ctx_wr.we   = 1'b0;
      ctx_wr.addr = req.ctx_index[CTX_AW-1:0];
      ctx_wr.data = req.data_byte[6:0];
      shifted = '0;
      byp_o   = '0;
      nst     = st;
      nmps    = mps;
      case (req.action)
         ACT_FEED: begin
            if (!ended_ff) begin
               if (zrun_ff == 2'd2 && req.data_byte == 8'd3) begin
                  zrun_in = 2'd0;
               end else if (zrun_ff == 2'd2 && req.data_byte <= 8'd2) begin
                  ended_in = 1'b1;
               end else if ({1'b0, cnt_ff} + (CNT_W+1)'(8) > (CNT_W+1)'(BUFFER_BITS)) begin
                  rsp.status = ST_FULL;
               end else begin
                  buf_in = {buf_ff[BUFFER_BITS-9:0], req.data_byte};
                  cnt_in = cnt_ff + CNT_W'(8);
                  if (req.data_byte != 8'd0) begin
                     zrun_in = 2'd0;
                  end else if (zrun_ff != 2'd2) begin
                     zrun_in = zrun_ff + 2'd1;
                  end
               end
            end
         end
         ACT_CTX_WRITE: begin
            ctx_wr.we = in_range;
         end
         ACT_START: begin
            if (!ready) begin
               rsp.status = ST_STARVED;
            end else begin
               if (tv[15:9] != 7'((8'd1 << align) - 8'd1)) begin
                  rsp.status = ST_ALIGN;
               end
               cnt_in    = cnt_taken;
               range_in  = 9'd510;
               offset_in = (tv[8:0] >= 9'd510) ? 9'd509 : tv[8:0];
            end
         end
         ACT_DECISION: begin
            if (lps_path) begin
               if (st == 6'd0) begin
                  nmps = ~mps;
               end
               nst = NEXT_ON_LPS[st];
            end else begin
               nst = (st < 6'd62) ? st + 6'd1 : st;
            end
            if (!ready) begin
               rsp.status = ST_STARVED;
            end else begin
               rsp.bin_value = lps_path ? ~mps : mps;
               shifted   = ({9'd0, dec_o} << dec_s) | {9'd0, tv[8:0]};
               offset_in = shifted[8:0];
               shifted   = {9'd0, dec_r} << dec_s;
               range_in  = shifted[8:0];
               cnt_in    = cnt_taken;
               ctx_wr.we   = in_range;
               ctx_wr.data = {nst, nmps};
            end
         end
         ACT_BYPASS: begin
            if (!ready) begin
               rsp.status = ST_STARVED;
            end else begin
               byp_o = {offset_ff, tv[0]};
               if (byp_o >= {1'b0, range_ff}) begin
                  rsp.bin_value = 1'b1;
                  byp_o = byp_o - {1'b0, range_ff};
               end
               offset_in = byp_o[8:0];
               cnt_in    = cnt_taken;
            end
         end
         ACT_TERMINATE: begin
            if (term_hit) begin
               rsp.bin_value = 1'b1;
               range_in      = term_r;
            end else if (!ready) begin
               rsp.status = ST_STARVED;
            end else begin
               shifted   = ({9'd0, offset_ff} << term_s) | {9'd0, tv[8:0]};
               offset_in = shifted[8:0];
               shifted   = {9'd0, term_r} << term_s;
               range_in  = shifted[8:0];
               cnt_in    = cnt_taken;
            end
         end
         default: begin
         end
      endcase
      if (!exec) begin
         ctx_wr.we = 1'b0;
      end
      rsp.end_seen = ended_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= 9'd510;
         offset_ff <= '0;
         buf_ff    <= '0;
         cnt_ff    <= '0;
         zrun_ff   <= '0;
         ended_ff  <= 1'b0;
      end else if (exec) begin
         range_ff  <= range_in;
         offset_ff <= offset_in;
         buf_ff    <= buf_in;
         cnt_ff    <= cnt_in;
         zrun_ff   <= zrun_in;
         ended_ff  <= ended_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(BUFFER_BITS))
      else $error("bit count exceeds buffer size");
   assert property (@(posedge clock) disable iff (reset) zrun_ff != 2'd3)
      else $error("zero run counter past saturation");
   assert property (@(posedge clock) disable iff (reset)
      ended_ff |=> ended_ff)
      else $error("end of stream flag cleared");

endmodule

[rtl/cabac_binary_arithmetic_decoder.sv]
// ----------------------------------------------------------------------------
// CABAC binary arithmetic decoder
// Top level: request stage, context memory, decode engine and result register.
// ----------------------------------------------------------------------------
// The decoder takes one request transfer per clock cycle unless the result side
// stalls, and returns exactly one result transfer for each, in order. A request
// is accepted into a first stage while its context entry is read from the
// synchronous context memory; once the result register can take it, the decode
// engine updates range, offset and bit buffer, writes the context back, and
// loads the result register. Without result stalls, throughput is one item
// per cycle, set by the context read-modify-write, with a write-to-read
// bypass so back-to-back bins on the same context see the newest state.
// The context memory has no reset: a context must be written before a
// decision bin uses it. Stalls on the result side propagate back to req_tready.
// ----------------------------------------------------------------------------
module cabac_binary_arithmetic_decoder
   import cabac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // action[2:0], ctx_index[12:3], data_byte[20:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // bin_value[0], status[2:1], end_seen[3]
);

   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_req_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   logic       req_xfer;
   logic       out_free;
   logic       s1_move;
   logic [6:0] ctx_val;
   rsp_type    eng_rsp;
   ctx_wr_type ctx_wr;
   req_type    req_in;

   assign req_in   = req_type'(req_tdata[20:0]);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_move  = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer = req_tvalid && req_tready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);

   cabac_ctx_mem u_ctx_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_addr (req_in.ctx_index[CTX_AW-1:0]),
      .wr      (ctx_wr),
      .rd_data (ctx_val)
   );

   cabac_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .exec    (s1_move),
      .req     (s1_req_ff),
      .ctx_val (ctx_val),
      .rsp     (eng_rsp),
      .ctx_wr  (ctx_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_req_ff <= req_in;
      end
      if (s1_move) begin
         rsp_ff <= eng_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff};

   assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_tvalid)
      else $error("executed item did not reach the result register");
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("stalled item lost from first stage");
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !req_tready)
      else $error("request accepted while first stage is blocked");

endmodule
